// ===== src/led_comet_frame_encoder_defines.svh =====
// Assertion macros for the LED comet frame encoder top level.
// Depends on nothing; included by the top level only.
`ifndef LED_COMET_FRAME_ENCODER_DEFINES_SVH
`define LED_COMET_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCFE_ASSERT_NOW(label, clk, rst_n, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (check)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCFE_ASSERT_NEXT(label, clk, rst_n, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (check)) \
        else $error(msg);

`endif

// ===== src/lcfe_pkg.sv =====
// Shared types, constants and color functions of the LED comet frame encoder.
// Depends on nothing; used by every module of the block.
package lcfe_pkg;

    localparam int STRIP_LENGTH = 32;
    localparam int IDX_W        = 6;
    localparam int POS_W        = 8;
    localparam int LEVEL_W      = 5;
    localparam int WORD_W       = 24;
    localparam int SUM_W        = 10;
    localparam int N_WRITES     = 14;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W    = 2;

    localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(STRIP_LENGTH - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        PK_CENTER,
        PK_NEAR,
        PK_MID,
        PK_TAIL_HALF,
        PK_TAIL_FULL
    } t_paint_kind;

    // The fourteen writes in the order they are applied; later ones win.
    localparam t_paint_kind PAINT_KIND [N_WRITES] = '{
        PK_CENTER, PK_NEAR, PK_NEAR, PK_MID, PK_MID, PK_TAIL_HALF, PK_TAIL_HALF,
        PK_CENTER, PK_NEAR, PK_NEAR, PK_MID, PK_MID, PK_TAIL_FULL, PK_TAIL_FULL
    };

    localparam logic signed [SUM_W-1:0] PAINT_OFFSET [N_WRITES] = '{
        10'sd0, -10'sd1, 10'sd1, -10'sd2, 10'sd2, -10'sd3, 10'sd3,
        10'sd0, -10'sd1, 10'sd1, -10'sd2, 10'sd2, -10'sd3, 10'sd3
    };

    typedef struct packed {
        logic [N_WRITES-1:0][IDX_W-1:0] slot;
    } t_frame_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_levels;

    // Far indexes land on LED 0; near overflow wraps once by the strip size.
    function automatic logic [IDX_W-1:0] wrap_slot(input logic signed [SUM_W-1:0] idx);
        logic signed [SUM_W-1:0] len;
        logic signed [SUM_W-1:0] res;
        len = SUM_W'(STRIP_LENGTH);
        if (idx >= (len <<< 1) || idx < -len) begin
            res = '0;
        end else if (idx >= len) begin
            res = idx - len;
        end else if (idx < 0) begin
            res = idx + len;
        end else begin
            res = idx;
        end
        return res[IDX_W-1:0];
    endfunction

    // GRB word: three zero bits ahead of each five-bit color.
    function automatic logic [WORD_W-1:0] paint_word(input t_paint_kind kind,
                                                     input t_levels lv);
        logic [LEVEL_W-1:0] pr;
        logic [LEVEL_W-1:0] pg;
        logic [LEVEL_W-1:0] pb;
        pr = lv.red;
        pg = '0;
        pb = '0;
        case (kind)
            PK_CENTER: begin
                pg = lv.green;
                pb = lv.blue;
            end
            PK_NEAR: begin
                pg = lv.green;
                pb = lv.blue >> 1;
            end
            PK_MID: begin
                pg = lv.green >> 1;
            end
            PK_TAIL_HALF: begin
                pr = lv.red >> 1;
            end
            PK_TAIL_FULL: begin
                pr = lv.red;
            end
            default: begin
                pr = '0;
            end
        endcase
        return {3'b000, pg, 3'b000, pr, 3'b000, pb};
    endfunction

endpackage

// ===== src/lcfe_front.sv =====
// Front end: turns a frame position into the fourteen wrapped LED slots.
// Depends on lcfe_pkg.
module lcfe_front (
    input  logic [lcfe_pkg::POS_W-1:0] i_frame_position,
    output lcfe_pkg::t_frame_job       o_job
);

    logic signed [lcfe_pkg::SUM_W-1:0] pos;
    logic signed [lcfe_pkg::SUM_W-1:0] mir;

    assign pos = signed'(lcfe_pkg::SUM_W'(i_frame_position));
    assign mir = signed'(lcfe_pkg::SUM_W'(lcfe_pkg::STRIP_LENGTH)) - pos;

    // The second half of the writes paints the mirror comet.
    always_comb begin
        for (int k = 0; k < lcfe_pkg::N_WRITES; k++) begin
            if (k < lcfe_pkg::N_WRITES / 2) begin
                o_job.slot[k] = lcfe_pkg::wrap_slot(pos + lcfe_pkg::PAINT_OFFSET[k]);
            end else begin
                o_job.slot[k] = lcfe_pkg::wrap_slot(mir + lcfe_pkg::PAINT_OFFSET[k]);
            end
        end
    end

endmodule

// ===== src/lcfe_queue.sv =====
// Short job queue between the front end and the word generator.
// Depends on lcfe_pkg.
module lcfe_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  lcfe_pkg::t_frame_job      i_job,
    input  logic                      i_pop,
    output lcfe_pkg::t_frame_job      o_head,
    output lcfe_pkg::t_queue_status   o_status
);

    lcfe_pkg::t_frame_job                r_mem [lcfe_pkg::QUEUE_DEPTH];
    logic [lcfe_pkg::QPTR_W-1:0]         r_wr_ptr;
    logic [lcfe_pkg::QPTR_W-1:0]         r_rd_ptr;
    logic [lcfe_pkg::QCNT_W-1:0]         r_count;
    logic [lcfe_pkg::QCNT_W-1:0]         n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == lcfe_pkg::QCNT_W'(lcfe_pkg::QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== src/lcfe_back.sv =====
// Back end: walks the strip one LED per cycle and registers each code word.
// Depends on lcfe_pkg.
module lcfe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcfe_pkg::t_levels             i_levels,
    input  lcfe_pkg::t_frame_job          i_head,
    input  lcfe_pkg::t_queue_status       i_status,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [lcfe_pkg::IDX_W-1:0]    o_led_index,
    output logic [lcfe_pkg::WORD_W-1:0]   o_code_word,
    output logic                          o_last_led
);

    logic                          r_active;
    logic [lcfe_pkg::IDX_W-1:0]    r_led;
    lcfe_pkg::t_frame_job          r_job;
    logic                          r_valid;
    logic [lcfe_pkg::IDX_W-1:0]    r_index;
    logic [lcfe_pkg::WORD_W-1:0]   r_word;
    logic                          r_last;
    logic [lcfe_pkg::WORD_W-1:0]   n_word;
    logic                          at_last;

    assign at_last = (r_led == lcfe_pkg::LAST_LED);
    assign o_pop   = !i_status.empty && (!r_active || at_last);

    // Dark unless some write hits this LED; the latest matching write wins.
    always_comb begin
        n_word = '0;
        for (int k = 0; k < lcfe_pkg::N_WRITES; k++) begin
            if (r_job.slot[k] == r_led) begin
                n_word = lcfe_pkg::paint_word(lcfe_pkg::PAINT_KIND[k], i_levels);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_led    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
                r_led    <= '0;
            end else if (r_active && at_last) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                r_led <= r_led + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        r_index <= r_led;
        r_word  <= n_word;
        r_last  <= r_active && at_last;
    end

    assign o_valid     = r_valid;
    assign o_led_index = r_index;
    assign o_code_word = r_word;
    assign o_last_led  = r_last && r_valid;

endmodule

// ===== src/led_comet_frame_encoder.sv =====
// Top level of the LED comet frame encoder: level registers, front end, queue
// and word generator. Depends on lcfe_pkg, lcfe_front, lcfe_queue, lcfe_back
// and the assertion macros in led_comet_frame_encoder_defines.svh.
//
// A frame position is taken as one beat at a rising edge where start is high
// and busy is low. For each position the block emits one beat per LED of the
// strip, index 0 first, each on o_led_index, o_code_word and o_last_led for
// exactly one cycle while o_valid is high; o_last_led marks the final LED.
// When the block is otherwise idle, the first word of a frame passes the
// queue, then the generator's LED walk and then the output registers. The
// word generator walks the strip one LED a cycle.
// Queued frames run back to back: a two-entry queue holds positions
// already accepted, and busy is high only while that queue is full.
// The receiver cannot stall, so words leave at the full rate once started.
// Level registers are written over i_cfg_we/i_cfg_index/i_cfg_data at any
// edge; an index beyond blue is ignored. Writes belong in idle periods.
// Synchronous active-low reset empties the queue, stops the generator and
// clears the three levels to zero.
`include "led_comet_frame_encoder_defines.svh"

module led_comet_frame_encoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lcfe_pkg::POS_W-1:0]        i_frame_position,
    input  logic                              i_cfg_we,
    input  logic [lcfe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcfe_pkg::LEVEL_W-1:0]      i_cfg_data,
    output logic                              o_valid,
    output logic [lcfe_pkg::IDX_W-1:0]        o_led_index,
    output logic [lcfe_pkg::WORD_W-1:0]       o_code_word,
    output logic                              o_last_led
);

    lcfe_pkg::t_levels         r_levels;
    lcfe_pkg::t_frame_job      front_job;
    lcfe_pkg::t_frame_job      queue_head;
    lcfe_pkg::t_queue_status   queue_status;
    logic                      accept;
    logic                      pop;

    // Level registers. Only the three listed indexes map to storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcfe_pkg::CFG_RED:   r_levels.red   <= i_cfg_data;
                lcfe_pkg::CFG_GREEN: r_levels.green <= i_cfg_data;
                lcfe_pkg::CFG_BLUE:  r_levels.blue  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Busy only reflects queue space, not whether words are being produced.
    assign busy   = queue_status.full;
    assign accept = start && !busy;

    lcfe_front u_front (
        .i_frame_position (i_frame_position),
        .o_job            (front_job)
    );

    lcfe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_head   (queue_head),
        .o_status (queue_status)
    );

    lcfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_levels    (r_levels),
        .i_head      (queue_head),
        .i_status    (queue_status),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_led_index (o_led_index),
        .o_code_word (o_code_word),
        .o_last_led  (o_last_led)
    );

    // The final beat of a frame always carries the top LED index.
    `LCFE_ASSERT_NOW(a_last_index, i_clk, i_rst_n, o_valid && o_last_led, o_led_index == lcfe_pkg::LAST_LED, "last beat not on final LED")

    // Within a frame, beats are consecutive with rising LED index.
    `LCFE_ASSERT_NEXT(a_frame_contiguous, i_clk, i_rst_n, o_valid && !o_last_led, o_valid && (o_led_index == $past(o_led_index) + lcfe_pkg::IDX_W'(1)), "frame beats not contiguous")

    // A queued frame follows the previous one without a gap.
    `LCFE_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_valid && o_last_led && busy, o_valid && (o_led_index == '0), "gap between queued frames")

endmodule
